// File: rtl/core/lkt_pkg.sv
`default_nettype none

package lkt_pkg;

    // sizing of the failure store
    localparam int RECORDS_PER_SOURCE = 16;
    localparam int NUM_SOURCES        = 64;

    localparam int SLOT_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int IDX_W   = (RECORDS_PER_SOURCE > 1) ? $clog2(RECORDS_PER_SOURCE) : 1;
    localparam int CNT_W   = $clog2(RECORDS_PER_SOURCE + 1);
    localparam int ADDR_W  = ((NUM_SOURCES * RECORDS_PER_SOURCE) > 1) ?
                             $clog2(NUM_SOURCES * RECORDS_PER_SOURCE) : 1;

    // field and register widths
    localparam int TIME_W      = 64;
    localparam int THR_W       = 8;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_CNT_W   = 5;
    localparam int OUT_CNT_MAX = 31;

    // register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd5;
    localparam logic [CFG_W-1:0] WINDOW_RST    = 32'd300;
    localparam logic [CFG_W-1:0] DELAY_RST     = 32'd300;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        OUT_RECORDED = 2'd0,
        OUT_SKIPPED  = 2'd1,
        OUT_CLEARED  = 2'd2,
        OUT_STATUS   = 2'd3
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOCK_THRESHOLD = 2'd0,
        REG_FAIL_WINDOW    = 2'd1,
        REG_UNLOCK_DELAY   = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN_MAX,
        S_SCAN_CNT,
        S_RESOLVE,
        S_STORE
    } state_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic             clr;
        logic             max_mode;
        logic             cnt_mode;
        logic             vld;
        logic [IDX_W-1:0] idx;
    } scan_ctrl_t;

    // flat address of one stored timestamp
    function automatic logic [ADDR_W-1:0] time_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [IDX_W-1:0] idx);
        time_addr = ADDR_W'(slot) * ADDR_W'(RECORDS_PER_SOURCE) + ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lkt_time_ram.sv
`default_nettype none

module lkt_time_ram
    import lkt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [TIME_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem_reg [NUM_SOURCES*RECORDS_PER_SOURCE];
    logic [TIME_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/lkt_scan_unit.sv
`default_nettype none

module lkt_scan_unit
    import lkt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scan_ctrl_t        ctrl,
    input  wire logic [TIME_W-1:0] data,
    input  wire logic [TIME_W-1:0] win_start,
    output      logic [TIME_W-1:0] latest,
    output      logic [IDX_W-1:0]  oldest_pos,
    output      logic [CNT_W-1:0]  count
);

    logic [TIME_W-1:0] latest_reg, latest_next;
    logic [TIME_W-1:0] oldest_reg, oldest_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // max / min tracking on one pass, window count on the other
    always_comb
    begin
        latest_next = latest_reg;
        oldest_next = oldest_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        if (ctrl.clr)
        begin
            latest_next = '0;
            cnt_next    = '0;
        end
        else if (ctrl.vld && ctrl.max_mode)
        begin
            if (data > latest_reg)
            begin
                latest_next = data;
            end
            // strict compare keeps the lowest index among equal stamps
            if ((ctrl.idx == '0) || (data < oldest_reg))
            begin
                oldest_next = data;
                pos_next    = ctrl.idx;
            end
        end
        else if (ctrl.vld && ctrl.cnt_mode)
        begin
            if (win_start < data)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg <= '0;
            oldest_reg <= '0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            latest_reg <= latest_next;
            oldest_reg <= oldest_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign latest     = latest_reg;
    assign oldest_pos = pos_reg;
    assign count      = cnt_reg;

endmodule

`default_nettype wire

// File: rtl/core/failed_attempt_lockout_tracker.sv
// steps: a clear goes from load to its result word; a query loads the fill count,
//   makes a max pass and a count pass over the slot and resolves; a record also
//   stores the stamp and scans again before it resolves; a skipped record resolves once
// throughput: one word at a time until its result word is registered; each scan reads one stamp a cycle
// reset: registers return to their defaults (threshold 5, window 300, delay 300),
//   per-slot fill counts read as empty at once; the stamp ram is not cleared
`default_nettype none

module failed_attempt_lockout_tracker
    import lkt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input channel
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic [5:0]           source_slot,
    input  wire logic [TIME_W-1:0]    now,
    input  wire logic                 check_lock_first,
    // output channel
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic                 locked,
    output      logic [TIME_W-1:0]    latest_fail_time,
    output      logic [OUT_CNT_W-1:0] valid_fail_count,
    output      logic [1:0]           outcome
);

    state_t                state_reg, state_next;
    opcode_t               op_reg, op_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic                  check_reg, check_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      iss_reg, iss_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  stored_reg, stored_next;
    logic [TIME_W-1:0]     start_reg, start_next;

    logic [THR_W-1:0]      thr_reg, thr_next;
    logic [CFG_W-1:0]      win_reg, win_next;
    logic [CFG_W-1:0]      dly_reg, dly_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  locked_reg, locked_next;
    logic [TIME_W-1:0]     latest_out_reg, latest_out_next;
    logic [OUT_CNT_W-1:0]  cnt_out_reg, cnt_out_next;
    outcome_t              outcome_reg, outcome_next;

    logic [CNT_W-1:0]      cnt_mem_reg [NUM_SOURCES];
    logic [CNT_W-1:0]      cnt_rd_reg;
    logic [NUM_SOURCES-1:0] cnt_vld_reg, cnt_vld_next;
    logic                  cnt_we;
    logic [CNT_W-1:0]      cnt_wdata;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [TIME_W-1:0]     ram_rd_data;

    scan_ctrl_t            scan_ctrl;
    logic [TIME_W-1:0]     scan_latest;
    logic [IDX_W-1:0]      scan_oldest_pos;
    logic [CNT_W-1:0]      scan_count;

    logic [TIME_W:0]       exp_sum;
    logic [TIME_W-1:0]     exp_sat;
    logic                  expired;
    logic [CNT_W-1:0]      cnt_eff;
    logic                  lock_eval;
    logic                  in_acc;
    logic                  out_free;
    logic [SLOT_W-1:0]     slot_in;
    logic                  issue;
    logic [IDX_W-1:0]      store_pos;
    logic [CNT_W-1:0]      n_after;

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign slot_in  = source_slot[SLOT_W-1:0];

    lkt_time_ram u_time_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (now_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lkt_scan_unit u_scan_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .data       (ram_rd_data),
        .win_start  (start_reg),
        .latest     (scan_latest),
        .oldest_pos (scan_oldest_pos),
        .count      (scan_count)
    );

    // per-slot fill count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem_reg[slot_reg] <= cnt_wdata;
        end
        if (in_acc)
        begin
            cnt_rd_reg <= cnt_mem_reg[slot_in];
        end
    end

    // expiry with saturation at the top of the time range, then lock decision
    always_comb
    begin
        exp_sum   = {1'b0, scan_latest} + (TIME_W+1)'(dly_reg);
        exp_sat   = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
        expired   = (exp_sat < now_reg);
        cnt_eff   = expired ? '0 : scan_count;
        lock_eval = (thr_reg != '0) && (int'(cnt_eff) >= int'(thr_reg));
    end

    // configuration writes
    always_comb
    begin
        thr_next = thr_reg;
        win_next = win_reg;
        dly_next = dly_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LOCK_THRESHOLD: thr_next = cfg_data[THR_W-1:0];
                REG_FAIL_WINDOW:    win_next = cfg_data;
                REG_UNLOCK_DELAY:   dly_next = cfg_data;
                default:            ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        now_next        = now_reg;
        check_next      = check_reg;
        n_next          = n_reg;
        iss_next        = iss_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        stored_next     = stored_reg;
        start_next      = start_reg;
        cnt_vld_next    = cnt_vld_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        locked_next     = locked_reg;
        latest_out_next = latest_out_reg;
        cnt_out_next    = cnt_out_reg;
        outcome_next    = outcome_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = '0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        in_ready        = 1'b0;
        issue           = 1'b0;
        store_pos       = '0;
        n_after         = '0;
        scan_ctrl       = '{clr: 1'b0, max_mode: 1'b0, cnt_mode: 1'b0,
                            vld: rd_vld_reg, idx: rd_idx_reg};

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (opcode)
                        OP_RECORD: op_next = OP_RECORD;
                        OP_CLEAR:  op_next = OP_CLEAR;
                        default:   op_next = OP_QUERY;
                    endcase
                    slot_next   = slot_in;
                    now_next    = now;
                    check_next  = check_lock_first;
                    stored_next = 1'b0;
                    state_next  = S_LOAD;
                end
            end

            S_LOAD:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    if (out_free)
                    begin
                        cnt_vld_next[slot_reg] = 1'b0;
                        out_valid_next  = 1'b1;
                        locked_next     = 1'b0;
                        latest_out_next = '0;
                        cnt_out_next    = '0;
                        outcome_next    = OUT_CLEARED;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    n_next        = cnt_vld_reg[slot_reg] ? cnt_rd_reg : '0;
                    iss_next      = '0;
                    scan_ctrl.clr = 1'b1;
                    state_next    = S_SCAN_MAX;
                end
            end

            S_SCAN_MAX, S_SCAN_CNT:
            begin
                scan_ctrl.max_mode = (state_reg == S_SCAN_MAX);
                scan_ctrl.cnt_mode = (state_reg == S_SCAN_CNT);
                // one ram read per cycle, data arrives the cycle after
                issue = (iss_reg < n_reg);
                if (issue)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = time_addr(slot_reg, iss_reg[IDX_W-1:0]);
                    iss_next    = iss_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[IDX_W-1:0];
                end
                else if (!rd_vld_reg)
                begin
                    iss_next = '0;
                    if (state_reg == S_SCAN_MAX)
                    begin
                        // window start saturates at zero
                        start_next = (scan_latest > TIME_W'(win_reg)) ?
                                     scan_latest - TIME_W'(win_reg) : '0;
                        state_next = S_SCAN_CNT;
                    end
                    else
                    begin
                        state_next = S_RESOLVE;
                    end
                end
            end

            S_RESOLVE:
            begin
                if ((op_reg == OP_RECORD) && !stored_reg && !(check_reg && lock_eval))
                begin
                    state_next = S_STORE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    locked_next     = lock_eval;
                    latest_out_next = scan_latest;
                    cnt_out_next    = (int'(cnt_eff) > OUT_CNT_MAX) ?
                                      OUT_CNT_W'(OUT_CNT_MAX) : OUT_CNT_W'(cnt_eff);
                    if (op_reg == OP_RECORD)
                    begin
                        outcome_next = stored_reg ? OUT_RECORDED : OUT_SKIPPED;
                    end
                    else
                    begin
                        outcome_next = OUT_STATUS;
                    end
                    state_next = S_IDLE;
                end
            end

            S_STORE:
            begin
                // append while room is left, else overwrite the oldest stamp
                if (int'(n_reg) < RECORDS_PER_SOURCE)
                begin
                    store_pos = n_reg[IDX_W-1:0];
                    n_after   = n_reg + CNT_W'(1);
                end
                else
                begin
                    store_pos = scan_oldest_pos;
                    n_after   = CNT_W'(RECORDS_PER_SOURCE);
                end
                ram_wr_en              = 1'b1;
                ram_wr_addr            = time_addr(slot_reg, store_pos);
                cnt_we                 = 1'b1;
                cnt_wdata              = n_after;
                cnt_vld_next[slot_reg] = 1'b1;
                n_next                 = n_after;
                iss_next               = '0;
                stored_next            = 1'b1;
                scan_ctrl.clr          = 1'b1;
                state_next             = S_SCAN_MAX;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_QUERY;
            check_reg     <= 1'b0;
            n_reg         <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            stored_reg    <= 1'b0;
            cnt_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THRESHOLD_RST;
            win_reg       <= WINDOW_RST;
            dly_reg       <= DELAY_RST;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            check_reg     <= check_next;
            n_reg         <= n_next;
            iss_reg       <= iss_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            stored_reg    <= stored_next;
            cnt_vld_reg   <= cnt_vld_next;
            out_valid_reg <= out_valid_next;
            thr_reg       <= thr_next;
            win_reg       <= win_next;
            dly_reg       <= dly_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        now_reg        <= now_next;
        start_reg      <= start_next;
        locked_reg     <= locked_next;
        latest_out_reg <= latest_out_next;
        cnt_out_reg    <= cnt_out_next;
        outcome_reg    <= outcome_next;
    end

    assign out_valid        = out_valid_reg;
    assign locked           = locked_reg;
    assign latest_fail_time = latest_out_reg;
    assign valid_fail_count = cnt_out_reg;
    assign outcome          = outcome_reg;

    // a skipped record only happens on a locked slot
    a_skip_locked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome == OUT_SKIPPED)) |-> locked)
        else $error("skipped record reported without lock");

    // a cleared slot reports an empty status
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (outcome == OUT_CLEARED)) |->
        (!locked && (latest_fail_time == '0) && (valid_fail_count == '0)))
        else $error("clear word carries nonzero status");

    // the store step runs once per record and never for other operations
    a_store_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> ((op_reg == OP_RECORD) && !stored_reg))
        else $error("unexpected store step");

    // fill count never exceeds the slot depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(n_reg) <= RECORDS_PER_SOURCE))
        else $error("slot fill count out of range");

endmodule

`default_nettype wire
